FILE: hdl/cptp_pkg.sv
`default_nettype none

package cptp_pkg;

   // Field and datapath widths
   localparam int COORD_W     = 24;
   localparam int DIFF_W      = 25;
   localparam int OPND_W      = 26;
   localparam int PROD_W      = 52;
   localparam int DIV_W       = 51;
   localparam int T_FRAC_BITS = 24;
   localparam int TCNT_W      = 5;
   localparam int COUNT_W     = 5;
   localparam int MIN_VERTICES = 3;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      OUT_INSIDE = 2'd0,
      OUT_MOVED  = 2'd1,
      OUT_FEW    = 2'd2
   } outcome_type;

   typedef enum logic [3:0] {
      MUL_LHS, MUL_RHS, MUL_VX, MUL_VY, MUL_SX,
      MUL_SY, MUL_DX, MUL_DY, MUL_TX, MUL_TY
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      DST_LHS, DST_D1, DST_D2, DST_DIST
   } acc_dst_type;

   typedef enum logic [2:0] {
      E_NONE, E_A, E_B, E_SCALE_X, E_SCALE_Y
   } e_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_I_RD0, ST_I_LD0, ST_I_RD, ST_I_LD, ST_I_ML, ST_I_MR, ST_I_EV, ST_I_END,
      ST_C_RD0, ST_C_LD0, ST_C_RD, ST_C_LD,
      ST_C_M1, ST_C_M2, ST_C_M3, ST_C_M4, ST_C_M5, ST_C_CK, ST_C_DV,
      ST_C_TX, ST_C_TY, ST_C_TZ, ST_C_D1, ST_C_D2, ST_C_D3, ST_C_BS,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        mem_we;
      logic        rd_en;
      logic        ld_query;
      logic        clr_inside;
      logic        ld_a_rd;
      logic        ld_b_rd;
      logic        ld_a_b;
      logic        ld_b_a;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      acc_dst_type acc_dst;
      logic        eval_cross;
      logic        div_start;
      e_sel_type   e_sel;
      logic        take_best;
      logic        ld_out;
      outcome_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_poly;
      logic d1_le0;
      logic d2_le_d1;
      logic dist_lt;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/cptp_if.sv
`default_nettype none

interface cptp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [3:0]                          vertex_index;
   logic signed [cptp_pkg::COORD_W-1:0] x_coord;
   logic signed [cptp_pkg::COORD_W-1:0] y_coord;

   modport source (output valid, command, vertex_index, x_coord, y_coord, input ready);
   modport sink   (input valid, command, vertex_index, x_coord, y_coord, output ready);
endinterface

interface cptp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cptp_pkg::COORD_W-1:0] out_x;
   logic signed [cptp_pkg::COORD_W-1:0] out_y;
   logic [1:0]                          outcome;

   modport source (output valid, out_x, out_y, outcome, input ready);
   modport sink   (input valid, out_x, out_y, outcome, output ready);
endinterface

interface cptp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cptp_pkg::COUNT_W-1:0]       vertex_count;

   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/constrain_point_to_polygon.sv
// Channel   Dir  Payload                                   Transfer
// req_ch    in   command, vertex_index, x_coord, y_coord   valid && ready
// rsp_ch    out  out_x, out_y, outcome                     valid && ready
// csr_ch    in   vertex_count                              valid && ready
//
// A vertex write is taken in idle; a query with too few vertices goes straight
// to the finish state. Otherwise a query runs the ray-casting pass, then the
// nearest-point pass, then loads the result; both passes use the single shared
// multiplier, and the nearest-point pass uses the 24-step restoring divider.
// Reset is synchronous and clears the controller, the count and the result
// valid; the vertex table is not cleared. A stalled result holds in the
// output register; a new item is taken while it waits, and a query that
// finishes meanwhile waits for the register, holding off the input.
`default_nettype none

module constrain_point_to_polygon #(
   parameter int MAX_VERTICES = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   cptp_req_if.sink     req_ch,
   cptp_rsp_if.source   rsp_ch,
   cptp_csr_if.sink     csr_ch
);

   localparam int IW = $clog2(MAX_VERTICES);

   cptp_pkg::dp_cmd_type    cmd;
   cptp_pkg::dp_status_type st;
   logic [IW-1:0]           rd_addr;
   logic [IW-1:0]           wr_addr;

   cptp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_command (req_ch.command),
      .req_index   (req_ch.vertex_index),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_data    (csr_ch.vertex_count),
      .st          (st),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr)
   );

   cptp_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .in_x    (req_ch.x_coord),
      .in_y    (req_ch.y_coord),
      .st      (st),
      .out_x   (rsp_ch.out_x),
      .out_y   (rsp_ch.out_y),
      .outcome (rsp_ch.outcome)
   );

endmodule

`default_nettype wire

FILE: hdl/cptp_div.sv
`default_nettype none

module cptp_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [cptp_pkg::DIV_W-1:0]      num,
   input  wire logic [cptp_pkg::DIV_W-1:0]      den,
   output logic                                 done,
   output logic [cptp_pkg::T_FRAC_BITS-1:0]     quot
);

   localparam logic [cptp_pkg::TCNT_W-1:0] LAST_STEP =
      cptp_pkg::TCNT_W'(cptp_pkg::T_FRAC_BITS - 1);

   logic                             busy_ff, busy_in;
   logic [cptp_pkg::TCNT_W-1:0]      cnt_ff, cnt_in;
   logic [cptp_pkg::DIV_W-1:0]       rem_ff, rem_in;
   logic [cptp_pkg::DIV_W-1:0]       den_ff, den_in;
   logic [cptp_pkg::T_FRAC_BITS-1:0] quot_ff, quot_in;
   logic [cptp_pkg::DIV_W-1:0]       rem_sh;

   // One restoring step per cycle, one quotient bit each
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff[cptp_pkg::DIV_W-2:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= den_ff) begin
            rem_in  = rem_sh - den_ff;
            quot_in = {quot_ff[cptp_pkg::T_FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[cptp_pkg::T_FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = busy_ff && (cnt_ff == LAST_STEP);
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: hdl/cptp_dp.sv
`default_nettype none

module cptp_dp #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire cptp_pkg::dp_cmd_type                   cmd,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]        wr_addr,
   input  wire logic signed [cptp_pkg::COORD_W-1:0]    in_x,
   input  wire logic signed [cptp_pkg::COORD_W-1:0]    in_y,
   output cptp_pkg::dp_status_type                     st,
   output logic signed [cptp_pkg::COORD_W-1:0]         out_x,
   output logic signed [cptp_pkg::COORD_W-1:0]         out_y,
   output logic [1:0]                                  outcome
);

   localparam int CW = cptp_pkg::COORD_W;
   localparam int DW = cptp_pkg::DIFF_W;
   localparam int OW = cptp_pkg::OPND_W;
   localparam int PW = cptp_pkg::PROD_W;
   localparam int TW = cptp_pkg::T_FRAC_BITS;

   // Vertex table: x in the upper half, y in the lower half
   logic [2*CW-1:0] mem [MAX_VERTICES];
   logic [2*CW-1:0] rd_ff;

   logic signed [CW-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [CW-1:0] ex_ff, ey_ff, rx_ff, ry_ff;
   logic signed [CW-1:0] ex_in, ey_in;
   logic signed [CW-1:0] out_x_ff, out_y_ff;
   logic [1:0]           outcome_ff;

   logic signed [DW-1:0] vx, vy, sx, sy, dxe, dye;
   logic signed [DW-1:0] sx_mag, sy_mag;
   logic signed [OW-1:0] op_a, op_b;
   logic signed [PW-1:0] mul_res, prod_ff;
   logic signed [PW-1:0] lhs_ff, d1_ff, d2_ff, dist_ff, best_ff;
   logic signed [PW-1:0] acc_base, acc_val;
   logic [CW-1:0]        scale_mag;
   logic                 inside_ff, straddle, crossing;
   logic                 div_done;
   logic [TW-1:0]        quot;

   // Hold the vertex table and its registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[wr_addr] <= {in_x, in_y};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Differences of the current edge and query point
   assign vx  = {px_ff[CW-1], px_ff} - {ax_ff[CW-1], ax_ff};
   assign vy  = {py_ff[CW-1], py_ff} - {ay_ff[CW-1], ay_ff};
   assign sx  = {bx_ff[CW-1], bx_ff} - {ax_ff[CW-1], ax_ff};
   assign sy  = {by_ff[CW-1], by_ff} - {ay_ff[CW-1], ay_ff};
   assign dxe = {px_ff[CW-1], px_ff} - {ex_ff[CW-1], ex_ff};
   assign dye = {py_ff[CW-1], py_ff} - {ey_ff[CW-1], ey_ff};
   assign sx_mag = sx[DW-1] ? -sx : sx;
   assign sy_mag = sy[DW-1] ? -sy : sy;

   // Select the operands of the shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         cptp_pkg::MUL_LHS: begin op_a = {vx[DW-1], vx};   op_b = {sy[DW-1], sy};   end
         cptp_pkg::MUL_RHS: begin op_a = {sx[DW-1], sx};   op_b = {vy[DW-1], vy};   end
         cptp_pkg::MUL_VX:  begin op_a = {vx[DW-1], vx};   op_b = {sx[DW-1], sx};   end
         cptp_pkg::MUL_VY:  begin op_a = {vy[DW-1], vy};   op_b = {sy[DW-1], sy};   end
         cptp_pkg::MUL_SX:  begin op_a = {sx[DW-1], sx};   op_b = {sx[DW-1], sx};   end
         cptp_pkg::MUL_SY:  begin op_a = {sy[DW-1], sy};   op_b = {sy[DW-1], sy};   end
         cptp_pkg::MUL_DX:  begin op_a = {dxe[DW-1], dxe}; op_b = {dxe[DW-1], dxe}; end
         cptp_pkg::MUL_DY:  begin op_a = {dye[DW-1], dye}; op_b = {dye[DW-1], dye}; end
         cptp_pkg::MUL_TX:  begin op_a = {1'b0, sx_mag};   op_b = {2'b00, quot};    end
         cptp_pkg::MUL_TY:  begin op_a = {1'b0, sy_mag};   op_b = {2'b00, quot};    end
         default:           begin op_a = '0;               op_b = '0;               end
      endcase
   end

   assign mul_res = op_a * op_b;

   // Accumulate products into the named sums
   always_comb begin
      unique case (cmd.acc_dst)
         cptp_pkg::DST_LHS:  acc_base = lhs_ff;
         cptp_pkg::DST_D1:   acc_base = d1_ff;
         cptp_pkg::DST_D2:   acc_base = d2_ff;
         cptp_pkg::DST_DIST: acc_base = dist_ff;
         default:            acc_base = '0;
      endcase
      acc_val = (cmd.acc_op == cptp_pkg::ACC_ADD) ? acc_base + prod_ff : prod_ff;
   end

   // Scale the edge by the quotient, truncating toward zero
   assign scale_mag = prod_ff[2*TW-1:TW];

   always_comb begin
      ex_in = ex_ff;
      ey_in = ey_ff;
      unique case (cmd.e_sel)
         cptp_pkg::E_A: begin
            ex_in = ax_ff;
            ey_in = ay_ff;
         end
         cptp_pkg::E_B: begin
            ex_in = bx_ff;
            ey_in = by_ff;
         end
         cptp_pkg::E_SCALE_X: ex_in = sx[DW-1] ? ax_ff - scale_mag : ax_ff + scale_mag;
         cptp_pkg::E_SCALE_Y: ey_in = sy[DW-1] ? ay_ff - scale_mag : ay_ff + scale_mag;
         default: ;
      endcase
   end

   // Crossing test: rhs sits in the product register at evaluation
   assign straddle = (ay_ff > py_ff) != (by_ff > py_ff);
   assign crossing = (sy > 0) ? (lhs_ff < prod_ff) : (lhs_ff > prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else if (cmd.clr_inside) begin
         inside_ff <= 1'b0;
      end else if (cmd.eval_cross && straddle && crossing) begin
         inside_ff <= !inside_ff;
      end
   end

   // Advance the payload registers
   always_ff @(posedge clock) begin
      if (cmd.ld_query) begin
         px_ff <= in_x;
         py_ff <= in_y;
      end
      if (cmd.ld_a_rd) begin
         ax_ff <= rd_ff[2*CW-1:CW];
         ay_ff <= rd_ff[CW-1:0];
      end else if (cmd.ld_a_b) begin
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
      end
      if (cmd.ld_b_rd) begin
         bx_ff <= rd_ff[2*CW-1:CW];
         by_ff <= rd_ff[CW-1:0];
      end else if (cmd.ld_b_a) begin
         bx_ff <= ax_ff;
         by_ff <= ay_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_res;
      end
      if (cmd.acc_op != cptp_pkg::ACC_NONE) begin
         unique case (cmd.acc_dst)
            cptp_pkg::DST_LHS:  lhs_ff  <= acc_val;
            cptp_pkg::DST_D1:   d1_ff   <= acc_val;
            cptp_pkg::DST_D2:   d2_ff   <= acc_val;
            cptp_pkg::DST_DIST: dist_ff <= acc_val;
            default: ;
         endcase
      end
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      if (cmd.take_best) begin
         best_ff <= dist_ff;
         rx_ff   <= ex_ff;
         ry_ff   <= ey_ff;
      end
      if (cmd.ld_out) begin
         outcome_ff <= cmd.out_sel;
         if (cmd.out_sel == cptp_pkg::OUT_MOVED) begin
            out_x_ff <= rx_ff;
            out_y_ff <= ry_ff;
         end else begin
            out_x_ff <= px_ff;
            out_y_ff <= py_ff;
         end
      end
   end

   cptp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (d1_ff[cptp_pkg::DIV_W-1:0]),
      .den   (d2_ff[cptp_pkg::DIV_W-1:0]),
      .done  (div_done),
      .quot  (quot)
   );

   assign st.in_poly  = inside_ff;
   assign st.d1_le0   = d1_ff[PW-1] || (d1_ff == '0);
   assign st.d2_le_d1 = d2_ff <= d1_ff;
   assign st.dist_lt  = dist_ff < best_ff;
   assign st.div_done = div_done;

   assign out_x   = out_x_ff;
   assign out_y   = out_y_ff;
   assign outcome = outcome_ff;

endmodule

`default_nettype wire

FILE: hdl/cptp_ctrl.sv
`default_nettype none

module cptp_ctrl #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_command,
   input  wire logic [3:0]                          req_index,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cptp_pkg::COUNT_W-1:0]        csr_data,
   input  wire cptp_pkg::dp_status_type             st,
   output cptp_pkg::dp_cmd_type                     cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]          rd_addr,
   output logic [$clog2(MAX_VERTICES)-1:0]          wr_addr
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   cptp_pkg::state_type   state_ff, state_in;
   cptp_pkg::outcome_type outcome_ff, outcome_in;
   logic [IW-1:0]                 edge_ff, edge_in;
   logic [cptp_pkg::COUNT_W-1:0]  count_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]                 n_use;
   logic [IW-1:0]                 edge_nx;
   logic                          last, few, req_xfer, is_query;

   // Saturate the vertex count to the table size
   assign n_use   = (32'(count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_ff);
   assign last    = (32'(edge_ff) + 1) == 32'(n_use);
   assign edge_nx = last ? '0 : edge_ff + 1'b1;
   assign few     = 32'(n_use) < cptp_pkg::MIN_VERTICES;

   assign req_ready = (state_ff == cptp_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign is_query  = (req_command == cptp_pkg::CMD_QUERY);
   assign wr_addr   = IW'(req_index);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      edge_in    = edge_ff;
      unique case (state_ff)
         cptp_pkg::ST_IDLE: begin
            if (req_xfer && is_query) begin
               if (few) begin
                  outcome_in = cptp_pkg::OUT_FEW;
                  state_in   = cptp_pkg::ST_FINISH;
               end else begin
                  state_in = cptp_pkg::ST_I_RD0;
               end
            end
         end
         cptp_pkg::ST_I_RD0: state_in = cptp_pkg::ST_I_LD0;
         cptp_pkg::ST_I_LD0: begin
            edge_in  = '0;
            state_in = cptp_pkg::ST_I_RD;
         end
         cptp_pkg::ST_I_RD: state_in = cptp_pkg::ST_I_LD;
         cptp_pkg::ST_I_LD: state_in = cptp_pkg::ST_I_ML;
         cptp_pkg::ST_I_ML: state_in = cptp_pkg::ST_I_MR;
         cptp_pkg::ST_I_MR: state_in = cptp_pkg::ST_I_EV;
         cptp_pkg::ST_I_EV: begin
            edge_in  = edge_nx;
            state_in = last ? cptp_pkg::ST_I_END : cptp_pkg::ST_I_RD;
         end
         cptp_pkg::ST_I_END: begin
            if (st.in_poly) begin
               outcome_in = cptp_pkg::OUT_INSIDE;
               state_in   = cptp_pkg::ST_FINISH;
            end else begin
               state_in = cptp_pkg::ST_C_RD0;
            end
         end
         cptp_pkg::ST_C_RD0: state_in = cptp_pkg::ST_C_LD0;
         cptp_pkg::ST_C_LD0: begin
            edge_in  = '0;
            state_in = cptp_pkg::ST_C_RD;
         end
         cptp_pkg::ST_C_RD: state_in = cptp_pkg::ST_C_LD;
         cptp_pkg::ST_C_LD: state_in = cptp_pkg::ST_C_M1;
         cptp_pkg::ST_C_M1: state_in = cptp_pkg::ST_C_M2;
         cptp_pkg::ST_C_M2: state_in = cptp_pkg::ST_C_M3;
         cptp_pkg::ST_C_M3: state_in = cptp_pkg::ST_C_M4;
         cptp_pkg::ST_C_M4: state_in = cptp_pkg::ST_C_M5;
         cptp_pkg::ST_C_M5: state_in = cptp_pkg::ST_C_CK;
         cptp_pkg::ST_C_CK: begin
            if (st.d1_le0 || st.d2_le_d1) begin
               state_in = cptp_pkg::ST_C_D1;
            end else begin
               state_in = cptp_pkg::ST_C_DV;
            end
         end
         cptp_pkg::ST_C_DV: begin
            if (st.div_done) begin
               state_in = cptp_pkg::ST_C_TX;
            end
         end
         cptp_pkg::ST_C_TX: state_in = cptp_pkg::ST_C_TY;
         cptp_pkg::ST_C_TY: state_in = cptp_pkg::ST_C_TZ;
         cptp_pkg::ST_C_TZ: state_in = cptp_pkg::ST_C_D1;
         cptp_pkg::ST_C_D1: state_in = cptp_pkg::ST_C_D2;
         cptp_pkg::ST_C_D2: state_in = cptp_pkg::ST_C_D3;
         cptp_pkg::ST_C_D3: state_in = cptp_pkg::ST_C_BS;
         cptp_pkg::ST_C_BS: begin
            edge_in = edge_nx;
            if (last) begin
               outcome_in = cptp_pkg::OUT_MOVED;
               state_in   = cptp_pkg::ST_FINISH;
            end else begin
               state_in = cptp_pkg::ST_C_RD;
            end
         end
         cptp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = cptp_pkg::ST_IDLE;
            end
         end
         default: state_in = cptp_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = cptp_pkg::MUL_LHS;
      cmd.acc_op  = cptp_pkg::ACC_NONE;
      cmd.acc_dst = cptp_pkg::DST_LHS;
      cmd.e_sel   = cptp_pkg::E_NONE;
      cmd.out_sel = outcome_ff;
      rd_addr     = edge_ff;
      unique case (state_ff)
         cptp_pkg::ST_IDLE: begin
            cmd.mem_we     = req_xfer && !is_query && (32'(req_index) < MAX_VERTICES);
            cmd.ld_query   = req_xfer && is_query;
            cmd.clr_inside = req_xfer && is_query;
         end
         cptp_pkg::ST_I_RD0: begin
            cmd.rd_en = 1'b1;
            rd_addr   = IW'(n_use - 1'b1);
         end
         cptp_pkg::ST_I_LD0: cmd.ld_b_rd = 1'b1;
         cptp_pkg::ST_I_RD:  cmd.rd_en   = 1'b1;
         cptp_pkg::ST_I_LD:  cmd.ld_a_rd = 1'b1;
         cptp_pkg::ST_I_ML: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_LHS;
         end
         cptp_pkg::ST_I_MR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_RHS;
            cmd.acc_op  = cptp_pkg::ACC_LOAD;
            cmd.acc_dst = cptp_pkg::DST_LHS;
         end
         cptp_pkg::ST_I_EV: begin
            cmd.eval_cross = 1'b1;
            cmd.ld_b_a     = 1'b1;
         end
         cptp_pkg::ST_I_END: ;
         cptp_pkg::ST_C_RD0: begin
            cmd.rd_en = 1'b1;
            rd_addr   = '0;
         end
         cptp_pkg::ST_C_LD0: cmd.ld_b_rd = 1'b1;
         cptp_pkg::ST_C_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.ld_a_b = 1'b1;
            rd_addr    = edge_nx;
         end
         cptp_pkg::ST_C_LD: cmd.ld_b_rd = 1'b1;
         cptp_pkg::ST_C_M1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_VX;
         end
         cptp_pkg::ST_C_M2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_VY;
            cmd.acc_op  = cptp_pkg::ACC_LOAD;
            cmd.acc_dst = cptp_pkg::DST_D1;
         end
         cptp_pkg::ST_C_M3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_SX;
            cmd.acc_op  = cptp_pkg::ACC_ADD;
            cmd.acc_dst = cptp_pkg::DST_D1;
         end
         cptp_pkg::ST_C_M4: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_SY;
            cmd.acc_op  = cptp_pkg::ACC_LOAD;
            cmd.acc_dst = cptp_pkg::DST_D2;
         end
         cptp_pkg::ST_C_M5: begin
            cmd.acc_op  = cptp_pkg::ACC_ADD;
            cmd.acc_dst = cptp_pkg::DST_D2;
         end
         cptp_pkg::ST_C_CK: begin
            if (st.d1_le0) begin
               cmd.e_sel = cptp_pkg::E_A;
            end else if (st.d2_le_d1) begin
               cmd.e_sel = cptp_pkg::E_B;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         cptp_pkg::ST_C_DV: ;
         cptp_pkg::ST_C_TX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_TX;
         end
         cptp_pkg::ST_C_TY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_TY;
            cmd.e_sel   = cptp_pkg::E_SCALE_X;
         end
         cptp_pkg::ST_C_TZ: cmd.e_sel = cptp_pkg::E_SCALE_Y;
         cptp_pkg::ST_C_D1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_DX;
         end
         cptp_pkg::ST_C_D2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cptp_pkg::MUL_DY;
            cmd.acc_op  = cptp_pkg::ACC_LOAD;
            cmd.acc_dst = cptp_pkg::DST_DIST;
         end
         cptp_pkg::ST_C_D3: begin
            cmd.acc_op  = cptp_pkg::ACC_ADD;
            cmd.acc_dst = cptp_pkg::DST_DIST;
         end
         cptp_pkg::ST_C_BS: cmd.take_best = (edge_ff == '0) || st.dist_lt;
         cptp_pkg::ST_FINISH: cmd.ld_out = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Hold the result valid until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.ld_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cptp_pkg::ST_IDLE;
         outcome_ff   <= cptp_pkg::OUT_FEW;
         edge_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outcome_ff   <= outcome_in;
         edge_ff      <= edge_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   // Checks
   a_few_goes_finish: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_query && few) |=> (state_ff == cptp_pkg::ST_FINISH))
      else $error("short polygon query did not go straight to finish");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !is_query) |=> (state_ff == cptp_pkg::ST_IDLE))
      else $error("vertex write left idle");

   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cptp_pkg::ST_C_BS || state_ff == cptp_pkg::ST_I_EV)
         |-> (32'(edge_ff) < 32'(n_use)))
      else $error("edge counter beyond vertex count");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cptp_pkg::ST_C_DV && !st.div_done) |=> (state_ff == cptp_pkg::ST_C_DV))
      else $error("left divide wait before quotient ready");

   a_out_only_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_out |-> (state_ff == cptp_pkg::ST_FINISH) && (state_in == cptp_pkg::ST_IDLE))
      else $error("result loaded outside finish");

endmodule

`default_nettype wire
